// ===== rtl/fjot_pkg.sv =====
// Package of the flat JSON object tokenizer: transfer payload types, lexer phases,
// character constants, token kinds and error codes.
// Depends on nothing; every other file of the block imports it.
package fjot_pkg;

    // One raw byte of the text, with a mark on the last byte.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_item_t;

    // One lexer result for each byte taken in.
    typedef struct packed {
        logic [7:0] data_char;
        logic [1:0] char_kind;
        logic       key_end;
        logic       value_end;
        logic       value_quoted;
        logic       object_done;
        logic [3:0] error_code;
    } out_item_t;

    // Lexer phases, one-hot.
    typedef enum logic [10:0] {
        PH_OPEN      = 11'b000_0000_0001,
        PH_FIRST     = 11'b000_0000_0010,
        PH_KEYQ      = 11'b000_0000_0100,
        PH_KEY       = 11'b000_0000_1000,
        PH_COLON     = 11'b000_0001_0000,
        PH_VALSTART  = 11'b000_0010_0000,
        PH_SVAL      = 11'b000_0100_0000,
        PH_RAW       = 11'b000_1000_0000,
        PH_AFTERVAL  = 11'b001_0000_0000,
        PH_TRAIL     = 11'b010_0000_0000,
        PH_EMPTYDONE = 11'b100_0000_0000
    } phase_t;

    // Token kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_STR  = 2'd2;
    localparam logic [1:0] KIND_RAW  = 2'd3;

    // Error codes.
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN     = 4'd1;
    localparam logic [3:0] ERR_EXP_STRING  = 4'd2;
    localparam logic [3:0] ERR_NO_COLON    = 4'd3;
    localparam logic [3:0] ERR_ESC_END     = 4'd4;
    localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd5;
    localparam logic [3:0] ERR_UNTERM_STR  = 4'd6;
    localparam logic [3:0] ERR_EMPTY_TOKEN = 4'd7;
    localparam logic [3:0] ERR_NO_SEP      = 4'd8;
    localparam logic [3:0] ERR_TRAILING    = 4'd9;
    localparam logic [3:0] ERR_UNEXP_END   = 4'd10;

    // Structural and escape characters.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Control bytes that the escapes stand for; tab to carriage return is also whitespace.
    localparam logic [7:0] DEC_BS  = 8'h08;
    localparam logic [7:0] DEC_TAB = 8'h09;
    localparam logic [7:0] DEC_LF  = 8'h0A;
    localparam logic [7:0] DEC_FF  = 8'h0C;
    localparam logic [7:0] DEC_CR  = 8'h0D;

endpackage

// ===== rtl/flat_json_object_tokenizer_core.sv =====
// Top level of the flat JSON object tokenizer: input register, lexer, result register.
// Depends on fjot_pkg and fjot_lexer.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------------
//  bytes    | byte_valid  | byte_stall  | byte_item (in_item_t)
//  tokens   | tok_valid   | tok_stall   | tok_item  (out_item_t)
//
// Every byte transfer gives exactly one token transfer, through the input register
// and then the result register; one byte is taken every cycle when nothing stalls,
// set by the single lexer step between the input register and the result register.
// Reset puts the lexer into the phase that waits for the opening brace.
// A stall on the tokens side holds the result register, then the input register,
// and only then raises byte_stall.
module flat_json_object_tokenizer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  fjot_pkg::in_item_t  byte_item,
    output logic                tok_valid,
    input  logic                tok_stall,
    output fjot_pkg::out_item_t tok_item
);
    import fjot_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      tok_valid_reg;
    out_item_t tok_item_reg;
    out_item_t lex_result;
    logic      out_free;
    logic      in_free;
    logic      step;

    assign out_free   = !tok_valid_reg || !tok_stall;
    assign in_free    = !in_valid_reg || out_free;
    assign step       = in_valid_reg && out_free;
    assign byte_stall = !in_free;
    assign tok_valid  = tok_valid_reg;
    assign tok_item   = tok_item_reg;

    fjot_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (lex_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= byte_valid;
            if (out_free)
                tok_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && byte_valid)
            in_item_reg <= byte_item;
        if (step)
            tok_item_reg <= lex_result;
    end

    // A completed object never carries an error code.
    a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> !(tok_item.object_done && tok_item.error_code != ERR_NONE))
        else $error("object_done given together with an error code");

    // A quoted flag only comes with the end of a value.
    a_quoted_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_item.value_quoted) |-> tok_item.value_end)
        else $error("value_quoted without value_end");

    // No decoded byte is shown without a kind.
    a_kind_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_item.char_kind == KIND_NONE) |-> tok_item.data_char == 8'd0)
        else $error("data byte present without a kind");

    // A held byte in the input register is not lost while the result side stalls.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register changed while stalled");

    // A key end and a value end never fall on the same byte.
    a_key_value_end: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> !(tok_item.key_end && tok_item.value_end))
        else $error("key_end and value_end on one byte");

endmodule

// ===== rtl/fjot_lexer.sv =====
// Lexer state and next-state logic of the flat JSON object tokenizer.
// Depends on fjot_pkg; the state advances by one byte whenever step is high.
module fjot_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  fjot_pkg::in_item_t  item,
    output fjot_pkg::out_item_t result
);
    import fjot_pkg::*;

    phase_t     phase_reg;
    logic       esc_reg;
    logic [3:0] err_reg;

    phase_t     phase_mid;
    logic       esc_mid;
    logic [3:0] code;
    logic [3:0] err_cur;
    logic       is_ws;

    logic       str_emit;
    logic       str_close;
    logic       str_esc;
    logic [7:0] str_dc;
    logic [3:0] str_err;

    assign is_ws = (item.in_byte inside {CH_SPACE, [DEC_TAB:DEC_CR]});

    // One byte inside a quoted string, shared by keys and string values.
    always_comb
    begin
        str_emit  = 1'b0;
        str_close = 1'b0;
        str_esc   = 1'b0;
        str_dc    = item.in_byte;
        str_err   = ERR_NONE;
        if (esc_reg)
        begin
            str_emit = 1'b1;
            case (item.in_byte)
                CH_QUOTE, CH_BSLASH, CH_SLASH: str_dc = item.in_byte;
                CH_B: str_dc = DEC_BS;
                CH_F: str_dc = DEC_FF;
                CH_N: str_dc = DEC_LF;
                CH_R: str_dc = DEC_CR;
                CH_T: str_dc = DEC_TAB;
                default:
                begin
                    str_emit = 1'b0;
                    str_err  = ERR_BAD_ESCAPE;
                end
            endcase
        end
        else if (item.in_byte == CH_QUOTE)
        begin
            str_close = 1'b1;
        end
        else if (item.in_byte == CH_BSLASH)
        begin
            if (item.is_final)
                str_err = ERR_ESC_END;
            else
                str_esc = 1'b1;
        end
        else
        begin
            str_emit = 1'b1;
        end
    end

    always_comb
    begin
        phase_mid = phase_reg;
        esc_mid   = esc_reg;
        code      = ERR_NONE;
        result    = '0;
        if (err_reg == ERR_NONE)
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    if (item.in_byte == CH_LBRACE)
                        phase_mid = PH_FIRST;
                    else if (!is_ws)
                        code = ERR_NO_OPEN;
                end
                PH_FIRST:
                begin
                    if (item.in_byte == CH_RBRACE)
                    begin
                        phase_mid          = PH_EMPTYDONE;
                        result.object_done = 1'b1;
                    end
                    else if (item.in_byte == CH_QUOTE)
                        phase_mid = PH_KEY;
                    else if (!is_ws)
                        code = ERR_EXP_STRING;
                end
                PH_KEYQ:
                begin
                    if (item.in_byte == CH_QUOTE)
                        phase_mid = PH_KEY;
                    else if (!is_ws)
                        code = ERR_EXP_STRING;
                end
                PH_KEY:
                begin
                    esc_mid = str_esc;
                    code    = str_err;
                    if (str_emit)
                    begin
                        result.data_char = str_dc;
                        result.char_kind = KIND_KEY;
                    end
                    if (str_close)
                    begin
                        result.key_end = 1'b1;
                        phase_mid      = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (item.in_byte == CH_COLON)
                        phase_mid = PH_VALSTART;
                    else if (!is_ws)
                        code = ERR_NO_COLON;
                end
                PH_VALSTART:
                begin
                    if (item.in_byte == CH_QUOTE)
                        phase_mid = PH_SVAL;
                    else if (item.in_byte == CH_COMMA || item.in_byte == CH_RBRACE)
                        code = ERR_EMPTY_TOKEN;
                    else if (!is_ws)
                    begin
                        result.data_char = item.in_byte;
                        result.char_kind = KIND_RAW;
                        phase_mid        = PH_RAW;
                    end
                end
                PH_SVAL:
                begin
                    esc_mid = str_esc;
                    code    = str_err;
                    if (str_emit)
                    begin
                        result.data_char = str_dc;
                        result.char_kind = KIND_STR;
                    end
                    if (str_close)
                    begin
                        result.value_end    = 1'b1;
                        result.value_quoted = 1'b1;
                        phase_mid           = PH_AFTERVAL;
                    end
                end
                PH_RAW:
                begin
                    if (item.in_byte == CH_COMMA)
                    begin
                        result.value_end = 1'b1;
                        phase_mid        = PH_KEYQ;
                    end
                    else if (item.in_byte == CH_RBRACE)
                    begin
                        result.value_end = 1'b1;
                        phase_mid        = PH_TRAIL;
                    end
                    else if (is_ws)
                    begin
                        result.value_end = 1'b1;
                        phase_mid        = PH_AFTERVAL;
                    end
                    else
                    begin
                        result.data_char = item.in_byte;
                        result.char_kind = KIND_RAW;
                    end
                end
                PH_AFTERVAL:
                begin
                    if (item.in_byte == CH_COMMA)
                        phase_mid = PH_KEYQ;
                    else if (item.in_byte == CH_RBRACE)
                        phase_mid = PH_TRAIL;
                    else if (!is_ws)
                        code = ERR_NO_SEP;
                end
                PH_TRAIL:
                begin
                    if (!is_ws)
                        code = ERR_TRAILING;
                end
                PH_EMPTYDONE:
                begin
                    result.object_done = 1'b1;
                end
                default:
                begin
                    phase_mid = PH_OPEN;
                end
            endcase

            // At text end the phase just reached decides the outcome.
            if (item.is_final && code == ERR_NONE)
            begin
                case (phase_mid)
                    PH_OPEN:               code = ERR_NO_OPEN;
                    PH_FIRST, PH_KEYQ:     code = ERR_UNEXP_END;
                    PH_KEY, PH_SVAL:       code = ERR_UNTERM_STR;
                    PH_COLON:              code = ERR_NO_COLON;
                    PH_VALSTART:           code = ERR_EMPTY_TOKEN;
                    PH_RAW:
                    begin
                        result.value_end    = 1'b1;
                        result.value_quoted = 1'b0;
                        code                = ERR_NO_SEP;
                    end
                    PH_AFTERVAL:           code = ERR_NO_SEP;
                    default:               result.object_done = 1'b1;
                endcase
            end
        end

        err_cur = (err_reg != ERR_NONE) ? err_reg : code;
        if (err_cur != ERR_NONE)
            result.object_done = 1'b0;
        result.error_code = err_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            esc_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (step)
        begin
            if (item.is_final)
            begin
                phase_reg <= PH_OPEN;
                esc_reg   <= 1'b0;
                err_reg   <= ERR_NONE;
            end
            else
            begin
                phase_reg <= phase_mid;
                esc_reg   <= esc_mid;
                err_reg   <= err_cur;
            end
        end
    end

endmodule

// ===== verif/flat_json_object_tokenizer_core_test.sv =====
// Self-checking testbench of the flat JSON object tokenizer: a byte driver and a
// token monitor around one instance, with an in-bench lexer that predicts every token.
// Depends on fjot_pkg and flat_json_object_tokenizer_core.
`timescale 1ns / 1ps

module flat_json_object_tokenizer_core_test;

    import fjot_pkg::*;

    localparam int TEXT_BYTES   = 1550;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AT      = 1000;
    localparam int HOLD_LEN     = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    in_item_t    byte_item = '0;
    logic        tok_valid;
    logic        tok_stall = 1'b0;
    out_item_t   tok_item;

    in_item_t    pending_bytes[$];
    out_item_t   expected_tokens[$];

    int          bytes_sent = 0;
    int          tokens_seen = 0;
    int          objects_done = 0;
    int          texts_built = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // Lexer state of the prediction.
    phase_t      lx_phase = PH_OPEN;
    bit          lx_esc = 1'b0;
    bit          lx_err = 1'b0;
    logic [3:0]  lx_code = ERR_NONE;

    logic [7:0]  esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                    CH_F, CH_N, CH_R, CH_T};
    logic [7:0]  disrupt_bytes[8] = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA,
                                      CH_QUOTE, CH_BSLASH, CH_SPACE, 8'h41};

    flat_json_object_tokenizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= DEC_TAB && b <= DEC_CR);
    endfunction

    // Only the first error of a text is kept.
    function automatic void raise_fault(input logic [3:0] code);
        if (!lx_err)
        begin
            lx_err = 1'b1;
            lx_code = code;
        end
    endfunction

    // One byte inside a quoted key or value; true on the closing quote.
    function automatic bit string_byte(input logic [7:0] b, input bit fin,
                                       input logic [1:0] kind, inout out_item_t r);
        logic [7:0] d;
        if (lx_esc)
        begin
            lx_esc = 1'b0;
            case (b)
                CH_QUOTE:  d = CH_QUOTE;
                CH_BSLASH: d = CH_BSLASH;
                CH_SLASH:  d = CH_SLASH;
                CH_B:      d = DEC_BS;
                CH_F:      d = DEC_FF;
                CH_N:      d = DEC_LF;
                CH_R:      d = DEC_CR;
                CH_T:      d = DEC_TAB;
                default:
                begin
                    raise_fault(ERR_BAD_ESCAPE);
                    return 1'b0;
                end
            endcase
            r.data_char = d;
            r.char_kind = kind;
            return 1'b0;
        end
        if (b == CH_QUOTE)
            return 1'b1;
        if (b == CH_BSLASH)
        begin
            if (fin)
                raise_fault(ERR_ESC_END);
            else
                lx_esc = 1'b1;
            return 1'b0;
        end
        r.data_char = b;
        r.char_kind = kind;
        return 1'b0;
    endfunction

    function automatic out_item_t lex_byte(input in_item_t it);
        out_item_t  r;
        logic [7:0] b;
        bit         fin;
        r = '0;
        b = it.in_byte;
        fin = it.is_final;
        if (!lx_err)
        begin
            case (lx_phase)
                PH_OPEN:
                    if (b == CH_LBRACE) lx_phase = PH_FIRST;
                    else if (!is_blank(b)) raise_fault(ERR_NO_OPEN);
                PH_FIRST:
                    if (b == CH_RBRACE)
                    begin
                        lx_phase = PH_EMPTYDONE;
                        r.object_done = 1'b1;
                    end
                    else if (b == CH_QUOTE) lx_phase = PH_KEY;
                    else if (!is_blank(b)) raise_fault(ERR_EXP_STRING);
                PH_KEYQ:
                    if (b == CH_QUOTE) lx_phase = PH_KEY;
                    else if (!is_blank(b)) raise_fault(ERR_EXP_STRING);
                PH_KEY:
                    if (string_byte(b, fin, KIND_KEY, r))
                    begin
                        r.key_end = 1'b1;
                        lx_phase = PH_COLON;
                    end
                PH_COLON:
                    if (b == CH_COLON) lx_phase = PH_VALSTART;
                    else if (!is_blank(b)) raise_fault(ERR_NO_COLON);
                PH_VALSTART:
                    if (b == CH_QUOTE) lx_phase = PH_SVAL;
                    else if (b == CH_COMMA || b == CH_RBRACE) raise_fault(ERR_EMPTY_TOKEN);
                    else if (!is_blank(b))
                    begin
                        r.data_char = b;
                        r.char_kind = KIND_RAW;
                        lx_phase = PH_RAW;
                    end
                PH_SVAL:
                    if (string_byte(b, fin, KIND_STR, r))
                    begin
                        r.value_end = 1'b1;
                        r.value_quoted = 1'b1;
                        lx_phase = PH_AFTERVAL;
                    end
                PH_RAW:
                    if (b == CH_COMMA)
                    begin
                        r.value_end = 1'b1;
                        lx_phase = PH_KEYQ;
                    end
                    else if (b == CH_RBRACE)
                    begin
                        r.value_end = 1'b1;
                        lx_phase = PH_TRAIL;
                    end
                    else if (is_blank(b))
                    begin
                        r.value_end = 1'b1;
                        lx_phase = PH_AFTERVAL;
                    end
                    else
                    begin
                        r.data_char = b;
                        r.char_kind = KIND_RAW;
                    end
                PH_AFTERVAL:
                    if (b == CH_COMMA) lx_phase = PH_KEYQ;
                    else if (b == CH_RBRACE) lx_phase = PH_TRAIL;
                    else if (!is_blank(b)) raise_fault(ERR_NO_SEP);
                PH_TRAIL:
                    if (!is_blank(b)) raise_fault(ERR_TRAILING);
                default:
                    r.object_done = 1'b1;
            endcase
        end

        // The phase in which the text ends decides its outcome.
        if (fin && !lx_err)
        begin
            case (lx_phase)
                PH_OPEN:              raise_fault(ERR_NO_OPEN);
                PH_FIRST, PH_KEYQ:    raise_fault(ERR_UNEXP_END);
                PH_KEY, PH_SVAL:      raise_fault(ERR_UNTERM_STR);
                PH_COLON:             raise_fault(ERR_NO_COLON);
                PH_VALSTART:          raise_fault(ERR_EMPTY_TOKEN);
                PH_RAW:
                begin
                    r.value_end = 1'b1;
                    r.value_quoted = 1'b0;
                    raise_fault(ERR_NO_SEP);
                end
                PH_AFTERVAL:          raise_fault(ERR_NO_SEP);
                default:              r.object_done = 1'b1;
            endcase
        end

        // An unterminated string or a cut-off raw token keeps its last data byte.
        if (lx_err)
        begin
            r.object_done = 1'b0;
            if (lx_code != ERR_UNTERM_STR && lx_code != ERR_NO_SEP)
            begin
                r.data_char = 8'h00;
                r.char_kind = KIND_NONE;
            end
        end
        r.error_code = lx_err ? lx_code : ERR_NONE;

        if (fin)
        begin
            lx_phase = PH_OPEN;
            lx_esc = 1'b0;
            lx_err = 1'b0;
            lx_code = ERR_NONE;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- text building

    function automatic void push_byte(input logic [7:0] b);
        in_item_t it;
        it.in_byte = b;
        it.is_final = 1'b0;
        pending_bytes = {pending_bytes, it};
    endfunction

    function automatic void end_text();
        pending_bytes[pending_bytes.size() - 1].is_final = 1'b1;
        texts_built++;
    endfunction

    function automatic void add_literal(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void add_blanks();
        logic [7:0] blanks[6] = '{DEC_TAB, DEC_LF, 8'h0B, DEC_FF, DEC_CR, CH_SPACE};
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 2))
                push_byte(blanks[$urandom_range(0, 5)]);
    endfunction

    function automatic void add_string();
        logic [7:0] b;
        push_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_byte(CH_BSLASH);
                if ($urandom_range(0, 9) == 0)
                    push_byte(8'($urandom_range(0, 255)));
                else
                    push_byte(esc_letters[$urandom_range(0, 7)]);
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                push_byte(b);
            end
        end
        push_byte(CH_QUOTE);
    endfunction

    function automatic void add_raw();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (is_blank(b) || b == CH_COMMA || b == CH_RBRACE || (i == 0 && b == CH_QUOTE));
            push_byte(b);
        end
    endfunction

    // Mostly well-formed objects with random content; a quarter get damaged.
    function automatic void add_random_text();
        int start;
        int roll;
        int pairs;
        int keep;
        start = pending_bytes.size();
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_blanks();
            push_byte(CH_LBRACE);
            add_blanks();
            pairs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++)
            begin
                if (p > 0)
                begin
                    push_byte(CH_COMMA);
                    add_blanks();
                end
                add_string();
                add_blanks();
                push_byte(CH_COLON);
                add_blanks();
                if ($urandom_range(0, 1) == 0)
                    add_string();
                else
                    add_raw();
                add_blanks();
            end
            push_byte(CH_RBRACE);
            if (pairs == 0)
                repeat ($urandom_range(0, 3))
                    push_byte(8'($urandom_range(0, 255)));
            else
            begin
                add_blanks();
                if ($urandom_range(0, 9) == 0)
                    push_byte(8'($urandom_range(33, 255)));
            end
            if (roll >= 75)
            begin
                if ($urandom_range(0, 1) == 0)
                    pending_bytes[$urandom_range(start, pending_bytes.size() - 1)].in_byte =
                        ($urandom_range(0, 1) == 0) ? disrupt_bytes[$urandom_range(0, 7)]
                                                    : 8'($urandom_range(0, 255));
                else
                begin
                    keep = $urandom_range(1, pending_bytes.size() - start - 1);
                    while (pending_bytes.size() > start + keep)
                        void'(pending_bytes.pop_back());
                end
            end
        end
        end_text();
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- byte driver

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        bit send_gap;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                expected_tokens = {expected_tokens, lex_byte(byte_item)};
                bytes_sent++;
            end
            send_gap = !(bytes_sent >= 300 && bytes_sent < 700) && $urandom_range(0, 99) < 7;
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && !send_gap)
                begin
                    byte_item <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- token monitor

    always @(posedge clk or negedge rst_n)
    begin : token_monitor
        out_item_t want;
        int        hold_left;
        bit        hold_done;
        if (!rst_n)
        begin
            tok_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                tokens_seen++;
                if (tok_item.object_done)
                    objects_done++;
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: token %h arrived with no byte waiting for it",
                             $time, tok_item);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_field("data_char", want.data_char, tok_item.data_char);
                    compare_field("char_kind", 8'(want.char_kind), 8'(tok_item.char_kind));
                    compare_field("key_end", 8'(want.key_end), 8'(tok_item.key_end));
                    compare_field("value_end", 8'(want.value_end), 8'(tok_item.value_end));
                    compare_field("value_quoted", 8'(want.value_quoted),
                                  8'(tok_item.value_quoted));
                    compare_field("object_done", 8'(want.object_done),
                                  8'(tok_item.object_done));
                    compare_field("error_code", 8'(want.error_code),
                                  8'(tok_item.error_code));
                end
            end
            // One long hold-off lets the pipeline fill and push the stall back to the bytes.
            if (hold_left > 0)
            begin
                hold_left--;
                tok_stall <= 1'b1;
            end
            else if (!hold_done && tokens_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                tok_stall <= 1'b1;
            end
            else
                tok_stall <= !(tokens_seen >= 300 && tokens_seen < 700)
                             && $urandom_range(0, 99) < 7;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("flat_json_object_tokenizer_core_test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        // Directed texts: empty object, escape cut by the text end, extreme bytes,
        // a key closed on the last byte, and an escaped string value.
        add_literal("{}");
        end_text();
        add_literal("{\"\\");
        end_text();
        push_byte(CH_LBRACE);
        push_byte(CH_QUOTE);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        push_byte(CH_COLON);
        push_byte(8'h00);
        push_byte(CH_RBRACE);
        end_text();
        add_literal("{\"a\"");
        end_text();
        add_literal("{\"k\":\"\\n\"}");
        end_text();

        while (pending_bytes.size() < TEXT_BYTES)
            add_random_text();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_valid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Lexed %0d bytes in %0d texts over %0d cycles, with one long token hold-off.",
                 bytes_sent, texts_built, cycle_count);
        $display("Checked %0d tokens field by field; %0d carried an accepted object.",
                 tokens_seen, objects_done);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("flat_json_object_tokenizer_core_test passed");
        else
            $display("flat_json_object_tokenizer_core_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fjot_pkg.sv
rtl/fjot_lexer.sv
rtl/flat_json_object_tokenizer_core.sv
verif/flat_json_object_tokenizer_core_test.sv
